@@ sv/text_console_buffer_top_assert.svh @@
// Assertion macros for the text console buffer.
`ifndef TEXT_CONSOLE_BUFFER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_BUFFER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TCB_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) expr) else $error(msg);
`define TCB_ASSERT_RST(label, expr, msg) \
   label: assert property (@(posedge clock) expr) else $error(msg);
`else
`define TCB_ASSERT(label, expr, msg)
`define TCB_ASSERT_RST(label, expr, msg)
`endif
`endif

@@ sv/tcb_pkg.sv @@
// Shared types, constants and helper functions of the text console buffer.
package tcb_pkg;

   localparam int STORE_ROWS = 64;
   localparam int STORE_COLS = 128;
   localparam int ROW_W      = $clog2(STORE_ROWS);
   localparam int COL_W      = $clog2(STORE_COLS);
   localparam int ADDR_W     = ROW_W + COL_W;

   localparam logic [7:0]  RST_COLS   = 8'd120;
   localparam logic [6:0]  RST_ROWS   = 7'd64;
   localparam logic [15:0] RST_PERIOD = 16'd3000;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;

   // Function codes of an input word.
   localparam logic [2:0] FN_PUT    = 3'd0;
   localparam logic [2:0] FN_SCROLL = 3'd1;
   localparam logic [2:0] FN_TICK   = 3'd2;
   localparam logic [2:0] FN_CLEAR  = 3'd3;
   localparam logic [2:0] FN_REFIT  = 3'd4;
   localparam logic [2:0] FN_READ   = 3'd5;

   // Display update commands.
   localparam logic [2:0] UPD_NONE    = 3'd0;
   localparam logic [2:0] UPD_DRAW    = 3'd1;
   localparam logic [2:0] UPD_ERASE   = 3'd2;
   localparam logic [2:0] UPD_REDRAW  = 3'd3;
   localparam logic [2:0] UPD_SHOW    = 3'd4;
   localparam logic [2:0] UPD_HIDE    = 3'd5;
   localparam logic [2:0] UPD_CLEAR   = 3'd6;
   localparam logic [2:0] UPD_RD_DRAW = 3'd7;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_COLS   = 2'd0;
   localparam logic [1:0] REG_ROWS   = 2'd1;
   localparam logic [1:0] REG_PERIOD = 2'd2;

   typedef enum logic [3:0] {
      OP_NEWLINE, OP_BACKSPACE, OP_CHAR, OP_SCROLL, OP_TICK,
      OP_CLEAR, OP_REFIT, OP_READ, OP_NOP
   } tcb_op_type;

   typedef struct packed {
      tcb_op_type  op;
      logic [7:0]  char_code;
      logic [7:0]  scroll_lines;
      logic [5:0]  cell_row;
      logic [6:0]  cell_col;
   } tcb_item_type;

   typedef struct packed {
      logic [7:0]  cols_in_use;
      logic [6:0]  rows_in_use;
      logic [15:0] blink_period;
   } tcb_cfg_type;

   typedef struct packed {
      logic [2:0] update_kind;
      logic [5:0] screen_row;
      logic [6:0] screen_col;
      logic [7:0] char_out;
      logic [5:0] cursor_row_out;
      logic [7:0] cursor_col_out;
      logic [5:0] view_top_out;
      logic       cursor_on;
   } tcb_rsp_type;

   // Column limit clamped to the range from 1 to the store width.
   function automatic logic [7:0] eff_cols(input logic [7:0] cols);
      logic [7:0] c;
      c = cols;
      if (c == 8'd0) c = 8'd1;
      if (c > 8'(STORE_COLS)) c = 8'(STORE_COLS);
      return c;
   endfunction

   // Row count clamped to the range from 1 to the store depth.
   function automatic logic [6:0] eff_rows(input logic [6:0] rows);
      logic [6:0] r;
      r = rows;
      if (r == 7'd0) r = 7'd1;
      if (r > 7'(STORE_ROWS)) r = 7'(STORE_ROWS);
      return r;
   endfunction

   // Lowest view top that keeps the cursor row visible.
   function automatic logic [5:0] top_limit(input logic [5:0] row, input logic [6:0] rows);
      logic [6:0] d;
      d = {1'b0, row} - rows + 7'd1;
      return ({1'b0, row} >= rows) ? d[5:0] : 6'd0;
   endfunction

endpackage

@@ sv/text_console_buffer_top.sv @@
// An accepted word passes through the two-entry queue, then the result register; a
// cell read also passes through the store read register. One word is taken per cycle
// while results are taken; a cell read holds the engine in its read state. A newline
// or wrap at the last row clears the recycled row first; a wrap then writes its
// character. A clear sweeps the whole store. Reset is synchronous; afterwards the
// same sweep runs before any word is taken. Configuration writes are taken at all times.
module text_console_buffer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[2:0], char_code[10:3], scroll_lines[18:11], cell_row[24:19], cell_col[31:25]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // update_kind[2:0], screen_row[8:3], screen_col[15:9], char_out[23:16],
   // cursor_row_out[29:24], cursor_col_out[37:30], view_top_out[43:38], cursor_on[44]
   output logic [47:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tcb_pkg::*;

   `include "text_console_buffer_top_assert.svh"

   tcb_cfg_type  cfg_ff, cfg_in;
   tcb_item_type item;
   tcb_rsp_type  rsp;
   logic         item_valid, item_ready, hold;
   logic         csr_wr;
   logic [1:0]   reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            REG_COLS:   cfg_in.cols_in_use  = csr_pwdata[7:0];
            REG_ROWS:   cfg_in.rows_in_use  = csr_pwdata[6:0];
            REG_PERIOD: cfg_in.blink_period = csr_pwdata[15:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_COLS:   csr_prdata = {24'd0, cfg_ff.cols_in_use};
         REG_ROWS:   csr_prdata = {25'd0, cfg_ff.rows_in_use};
         REG_PERIOD: csr_prdata = {16'd0, cfg_ff.blink_period};
         default:    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cols_in_use  <= RST_COLS;
         cfg_ff.rows_in_use  <= RST_ROWS;
         cfg_ff.blink_period <= RST_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (hold),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   tcb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .hold       (hold),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   // Result word packing, first field in the lowest bits.
   assign rsp_tdata = {3'b000, rsp.cursor_on, rsp.view_top_out, rsp.cursor_col_out,
                       rsp.cursor_row_out, rsp.char_out, rsp.screen_col, rsp.screen_row,
                       rsp.update_kind};

   // The cursor column never runs past the store width.
   `TCB_ASSERT(a_col_bound, rsp_tvalid |-> (rsp.cursor_col_out <= 8'd128), "cursor column")
   // The view top never lies below the cursor row.
   `TCB_ASSERT(a_view_le_row, rsp_tvalid |-> (rsp.view_top_out <= rsp.cursor_row_out), "view top")
   // The store sweep after reset keeps the input closed.
   `TCB_ASSERT_RST(a_sweep_after_reset, reset |=> !req_tready, "word taken during reset sweep")

endmodule

@@ sv/tcb_front.sv @@
// Front end: accepts input words, classifies them and queues them for the engine.
module tcb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  hold,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,
   output logic                  item_valid,
   input  logic                  item_ready,
   output tcb_pkg::tcb_item_type item
);
   import tcb_pkg::*;

   tcb_item_type queue_ff [2];
   logic         wptr_ff, wptr_in;
   logic         rptr_ff, rptr_in;
   logic [1:0]   count_ff, count_in;
   tcb_item_type cls;
   logic [2:0]   func;
   logic         push, pop;

   assign func = req_tdata[2:0];

   // Classify the word by function and, for a put, by the character.
   always_comb begin
      cls.char_code    = req_tdata[10:3];
      cls.scroll_lines = req_tdata[18:11];
      cls.cell_row     = req_tdata[24:19];
      cls.cell_col     = req_tdata[31:25];
      unique case (func)
         FN_PUT: begin
            if (cls.char_code == CH_NEWLINE) cls.op = OP_NEWLINE;
            else if (cls.char_code == CH_BACKSPACE) cls.op = OP_BACKSPACE;
            else cls.op = OP_CHAR;
         end
         FN_SCROLL: cls.op = OP_SCROLL;
         FN_TICK:   cls.op = OP_TICK;
         FN_CLEAR:  cls.op = OP_CLEAR;
         FN_REFIT:  cls.op = OP_REFIT;
         FN_READ:   cls.op = OP_READ;
         default:   cls.op = OP_NOP;
      endcase
   end

   assign req_tready = (count_ff != 2'd2) && !hold;
   assign item_valid = (count_ff != 2'd0);
   assign item       = queue_ff[rptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ pop;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   // Two-entry queue between the front and the engine.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) queue_ff[wptr_ff] <= cls;
   end

endmodule

@@ sv/tcb_back.sv @@
// Engine: owns the character store, cursor, view and blink state, and builds results.
module tcb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tcb_pkg::tcb_cfg_type  cfg,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  tcb_pkg::tcb_item_type item,
   output logic                  hold,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tcb_pkg::tcb_rsp_type  rsp
);
   import tcb_pkg::*;

   typedef enum logic [2:0] {
      ST_SWEEP = 3'b001,
      ST_IDLE  = 3'b010,
      ST_READ  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [7:0]         col_ff, col_in;
   logic [ROW_W-1:0]   view_ff, view_in;
   logic [15:0]        blink_ff, blink_in;
   logic               shown_ff, shown_in;
   logic [ROW_W-1:0]   base_ff, base_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic               sweep_all_ff, sweep_all_in;
   logic [ROW_W-1:0]   clr_row_ff, clr_row_in;
   logic               pend_ff, pend_in;
   logic [7:0]         pend_char_ff, pend_char_in;
   logic               rd_ok_ff, rd_ok_in;
   logic               out_valid_ff, out_valid_in;
   tcb_rsp_type        out_ff, out_in;

   logic [7:0]         store [STORE_ROWS*STORE_COLS];
   logic [7:0]         rdata_ff;
   logic               we;
   logic [ADDR_W-1:0]  waddr, raddr;
   logic [7:0]         wdata;

   logic               take, sweep_done, nl_shift;
   logic [7:0]         ecols;
   logic [6:0]         erows;
   logic [ROW_W-1:0]   nl_row, nl_view;
   logic [9:0]         view_target;
   logic [ROW_W-1:0]   lim;
   logic [16:0]        blink_next;
   logic [6:0]         read_row;
   logic [2:0]         kind;
   logic [ROW_W-1:0]   srow;
   logic [COL_W-1:0]   scol;
   logic [7:0]         cout;
   logic               load;

   assign ecols       = eff_cols(cfg.cols_in_use);
   assign erows       = eff_rows(cfg.rows_in_use);
   assign nl_shift    = (row_ff == ROW_W'(STORE_ROWS - 1));
   assign nl_row      = nl_shift ? row_ff : row_ff + 1'b1;
   assign nl_view     = top_limit(nl_row, erows);
   assign lim         = top_limit(row_ff, erows);
   assign view_target = $signed({4'b0, view_ff}) - $signed({{2{item.scroll_lines[7]}},
                                                            item.scroll_lines});
   assign blink_next  = {1'b0, blink_ff} + 17'd1;
   assign read_row    = {1'b0, view_ff} + {1'b0, item.cell_row};
   assign sweep_done  = sweep_all_ff ? (sweep_ff == '1) : (sweep_ff[COL_W-1:0] == '1);

   assign hold       = (state_ff == ST_SWEEP);
   assign take       = (state_ff == ST_IDLE) && !pend_ff && item_valid
                       && (!out_valid_ff || rsp_ready);
   assign item_ready = take;
   assign rsp_valid  = out_valid_ff;
   assign rsp        = out_ff;

   // Item execution, store sweeps and the result register.
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      view_in      = view_ff;
      blink_in     = blink_ff;
      shown_in     = shown_ff;
      base_in      = base_ff;
      sweep_in     = sweep_ff;
      sweep_all_in = sweep_all_ff;
      clr_row_in   = clr_row_ff;
      pend_in      = pend_ff;
      pend_char_in = pend_char_ff;
      rd_ok_in     = rd_ok_ff;
      we           = 1'b0;
      waddr        = '0;
      wdata        = '0;
      raddr        = {read_row[ROW_W-1:0] + base_ff, item.cell_col};
      kind         = UPD_NONE;
      srow         = '0;
      scol         = '0;
      cout         = '0;
      load         = 1'b0;

      unique case (state_ff)
         ST_SWEEP: begin
            we    = 1'b1;
            waddr = sweep_all_ff ? sweep_ff : {clr_row_ff, sweep_ff[COL_W-1:0]};
            sweep_in = sweep_ff + 1'b1;
            if (sweep_done) state_in = ST_IDLE;
         end
         ST_READ: begin
            load     = 1'b1;
            cout     = rd_ok_ff ? rdata_ff : 8'd0;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (pend_ff) begin
               // Character that waited for its freshly cleared row.
               we      = 1'b1;
               waddr   = {clr_row_ff, {COL_W{1'b0}}};
               wdata   = pend_char_ff;
               pend_in = 1'b0;
            end else if (take) begin
               load = 1'b1;
               unique case (item.op)
                  OP_NEWLINE: begin
                     kind    = UPD_REDRAW;
                     row_in  = nl_row;
                     col_in  = 8'd0;
                     view_in = nl_view;
                     if (nl_shift) begin
                        base_in      = base_ff + 1'b1;
                        clr_row_in   = base_ff;
                        sweep_in     = '0;
                        sweep_all_in = 1'b0;
                        state_in     = ST_SWEEP;
                     end
                  end
                  OP_BACKSPACE: begin
                     if (col_ff != 8'd0) begin
                        col_in = col_ff - 8'd1;
                        we     = 1'b1;
                        waddr  = {row_ff + base_ff, col_in[COL_W-1:0]};
                        kind   = UPD_ERASE;
                        srow   = row_ff - view_ff;
                        scol   = col_in[COL_W-1:0];
                     end
                  end
                  OP_CHAR: begin
                     cout = item.char_code;
                     if (col_ff >= ecols) begin
                        kind    = UPD_RD_DRAW;
                        row_in  = nl_row;
                        col_in  = 8'd1;
                        view_in = nl_view;
                        srow    = nl_row - nl_view;
                        scol    = '0;
                        if (nl_shift) begin
                           base_in      = base_ff + 1'b1;
                           clr_row_in   = base_ff;
                           sweep_in     = '0;
                           sweep_all_in = 1'b0;
                           pend_in      = 1'b1;
                           pend_char_in = item.char_code;
                           state_in     = ST_SWEEP;
                        end else begin
                           we    = 1'b1;
                           waddr = {nl_row + base_ff, {COL_W{1'b0}}};
                           wdata = item.char_code;
                        end
                     end else begin
                        kind   = UPD_DRAW;
                        we     = 1'b1;
                        waddr  = {row_ff + base_ff, col_ff[COL_W-1:0]};
                        wdata  = item.char_code;
                        srow   = row_ff - view_ff;
                        scol   = col_ff[COL_W-1:0];
                        col_in = col_ff + 8'd1;
                     end
                  end
                  OP_SCROLL: begin
                     kind = UPD_REDRAW;
                     if (view_target[9]) view_in = '0;
                     else if (view_target > {4'b0, lim}) view_in = lim;
                     else view_in = view_target[ROW_W-1:0];
                  end
                  OP_TICK: begin
                     if (blink_next >= {1'b0, cfg.blink_period}) begin
                        blink_in = '0;
                        shown_in = !shown_ff;
                        kind     = shown_ff ? UPD_HIDE : UPD_SHOW;
                        srow     = row_ff - view_ff;
                        scol     = col_ff[COL_W-1:0];
                     end else begin
                        blink_in = blink_next[15:0];
                     end
                  end
                  OP_CLEAR: begin
                     kind         = UPD_CLEAR;
                     row_in       = '0;
                     col_in       = 8'd0;
                     view_in      = '0;
                     sweep_in     = '0;
                     sweep_all_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  OP_REFIT: begin
                     kind    = UPD_REDRAW;
                     if (col_ff > ecols) col_in = ecols;
                     view_in = lim;
                  end
                  OP_READ: begin
                     load     = 1'b0;
                     rd_ok_in = (read_row < 7'(STORE_ROWS));
                     state_in = ST_READ;
                  end
                  default: begin
                     kind = UPD_NONE;
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase

      out_in.update_kind    = kind;
      out_in.screen_row     = srow;
      out_in.screen_col     = scol;
      out_in.char_out       = cout;
      out_in.cursor_row_out = row_in;
      out_in.cursor_col_out = col_in;
      out_in.view_top_out   = view_in;
      out_in.cursor_on      = shown_in;

      if (load) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   // State registers; reset starts a sweep of the whole store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         row_ff       <= '0;
         col_ff       <= 8'd0;
         view_ff      <= '0;
         blink_ff     <= 16'd0;
         shown_ff     <= 1'b1;
         base_ff      <= '0;
         sweep_ff     <= '0;
         sweep_all_ff <= 1'b1;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         view_ff      <= view_in;
         blink_ff     <= blink_in;
         shown_ff     <= shown_in;
         base_ff      <= base_in;
         sweep_ff     <= sweep_in;
         sweep_all_ff <= sweep_all_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      clr_row_ff   <= clr_row_in;
      pend_char_ff <= pend_char_in;
      rd_ok_ff     <= rd_ok_in;
      if (load) out_ff <= out_in;
   end

   // Character store, rows kept as a ring starting at the base row.
   always_ff @(posedge clock) begin
      if (we) store[waddr] <= wdata;
      rdata_ff <= store[raddr];
   end

endmodule

@@ tb/tb_text_console_buffer_top.sv @@
// Self-checking testbench for the text console buffer: stream words in, compare every result.
`timescale 1ns / 100ps

module tb_text_console_buffer_top;
   import tcb_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // func[2:0], char_code[10:3], scroll_lines[18:11], cell_row[24:19], cell_col[31:25]
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // update_kind[2:0], screen_row[8:3], screen_col[15:9], char_out[23:16],
   // cursor_row_out[29:24], cursor_col_out[37:30], view_top_out[43:38], cursor_on[44]
   logic [47:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   text_console_buffer_top u_top (.*);

   // Shadow of the console state and its registers.
   logic [7:0]  shadow_store [STORE_ROWS][STORE_COLS];
   int unsigned cur_row, cur_col, top_row, blink_cnt, shown;
   int unsigned grid_cols, grid_rows, period;

   tcb_rsp_type expected_updates [$];
   int          errors = 0;
   int          words_sent = 0;
   int          updates_seen = 0;
   int          cycles = 0;
   bit          idle_on = 1'b1;

   // Clock, 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Cycle counter with a hard limit on the run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d updates outstanding", $time, expected_updates.size());
         $display("tb_text_console_buffer_top: done, errors");
         $finish;
      end
   end

   // Result side back-pressure.
   always @(negedge clock) begin
      rsp_tready <= !idle_on || ($urandom_range(99) >= 28);
   end

   // Compare each accepted result word with the oldest expected update.
   always @(posedge clock) begin
      tcb_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.update_kind    = rsp_tdata[2:0];
         got.screen_row     = rsp_tdata[8:3];
         got.screen_col     = rsp_tdata[15:9];
         got.char_out       = rsp_tdata[23:16];
         got.cursor_row_out = rsp_tdata[29:24];
         got.cursor_col_out = rsp_tdata[37:30];
         got.view_top_out   = rsp_tdata[43:38];
         got.cursor_on      = rsp_tdata[44];
         updates_seen++;
         if (expected_updates.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_updates.pop_front();
            if (got.update_kind != want.update_kind) begin
               $display("%0t: update_kind exp %0d got %0d", $time, want.update_kind,
                        got.update_kind);
               errors++;
            end
            if (got.screen_row != want.screen_row) begin
               $display("%0t: screen_row exp %0d got %0d", $time, want.screen_row,
                        got.screen_row);
               errors++;
            end
            if (got.screen_col != want.screen_col) begin
               $display("%0t: screen_col exp %0d got %0d", $time, want.screen_col,
                        got.screen_col);
               errors++;
            end
            if (got.char_out != want.char_out) begin
               $display("%0t: char_out exp %0d got %0d", $time, want.char_out, got.char_out);
               errors++;
            end
            if (got.cursor_row_out != want.cursor_row_out) begin
               $display("%0t: cursor_row_out exp %0d got %0d", $time, want.cursor_row_out,
                        got.cursor_row_out);
               errors++;
            end
            if (got.cursor_col_out != want.cursor_col_out) begin
               $display("%0t: cursor_col_out exp %0d got %0d", $time, want.cursor_col_out,
                        got.cursor_col_out);
               errors++;
            end
            if (got.view_top_out != want.view_top_out) begin
               $display("%0t: view_top_out exp %0d got %0d", $time, want.view_top_out,
                        got.view_top_out);
               errors++;
            end
            if (got.cursor_on != want.cursor_on) begin
               $display("%0t: cursor_on exp %0d got %0d", $time, want.cursor_on,
                        got.cursor_on);
               errors++;
            end
         end
      end
   end

   function automatic int unsigned used_cols();
      return (grid_cols == 0) ? 1 : (grid_cols > STORE_COLS) ? STORE_COLS : grid_cols;
   endfunction

   function automatic int unsigned lowest_top();
      int unsigned r;
      r = (grid_rows == 0) ? 1 : (grid_rows > STORE_ROWS) ? STORE_ROWS : grid_rows;
      return (cur_row >= r) ? cur_row - r + 1 : 0;
   endfunction

   function automatic void wipe_store();
      foreach (shadow_store[r, c]) shadow_store[r][c] = 8'd0;
   endfunction

   // Move to the next line, scrolling the store up at its last row.
   function automatic void line_feed();
      cur_row++;
      cur_col = 0;
      if (cur_row >= STORE_ROWS) begin
         cur_row = STORE_ROWS - 1;
         for (int r = 0; r < STORE_ROWS - 1; r++)
            for (int c = 0; c < STORE_COLS; c++) shadow_store[r][c] = shadow_store[r + 1][c];
         for (int c = 0; c < STORE_COLS; c++) shadow_store[STORE_ROWS - 1][c] = 8'd0;
      end
      top_row = lowest_top();
   endfunction

   // Work out the update that one accepted word causes, and advance the shadow.
   function automatic void predict_update(input logic [31:0] w);
      logic [2:0]  fn;
      logic [7:0]  ch;
      int          lines, new_top;
      int unsigned rd_row;
      tcb_rsp_type u;
      fn = w[2:0];
      ch = w[10:3];
      u = '0;
      case (fn)
         FN_PUT: begin
            if (ch == CH_NEWLINE) begin
               line_feed();
               u.update_kind = UPD_REDRAW;
            end else if (ch == CH_BACKSPACE) begin
               if (cur_col > 0) begin
                  cur_col--;
                  shadow_store[cur_row][cur_col] = 8'd0;
                  u.update_kind = UPD_ERASE;
                  u.screen_row = 6'(cur_row - top_row);
                  u.screen_col = 7'(cur_col);
               end
            end else begin
               u.update_kind = UPD_DRAW;
               if (cur_col >= used_cols()) begin
                  line_feed();
                  u.update_kind = UPD_RD_DRAW;
               end
               shadow_store[cur_row][cur_col] = ch;
               u.screen_row = 6'(cur_row - top_row);
               u.screen_col = 7'(cur_col);
               u.char_out = ch;
               cur_col++;
            end
         end
         FN_SCROLL: begin
            lines = $signed(w[18:11]);
            new_top = int'(top_row) - lines;
            if (new_top < 0) new_top = 0;
            if (new_top > int'(lowest_top())) new_top = lowest_top();
            top_row = new_top;
            u.update_kind = UPD_REDRAW;
         end
         FN_TICK: begin
            blink_cnt++;
            if (blink_cnt >= period) begin
               blink_cnt = 0;
               shown ^= 1;
               u.update_kind = shown ? UPD_SHOW : UPD_HIDE;
               u.screen_row = 6'(cur_row - top_row);
               u.screen_col = 7'(cur_col);
            end
         end
         FN_CLEAR: begin
            wipe_store();
            cur_row = 0;
            cur_col = 0;
            top_row = 0;
            u.update_kind = UPD_CLEAR;
         end
         FN_REFIT: begin
            if (cur_col > used_cols()) cur_col = used_cols();
            top_row = lowest_top();
            u.update_kind = UPD_REDRAW;
         end
         FN_READ: begin
            rd_row = top_row + w[24:19];
            if (rd_row < STORE_ROWS) u.char_out = shadow_store[rd_row][w[31:25]];
         end
         default: ;
      endcase
      u.cursor_row_out = 6'(cur_row);
      u.cursor_col_out = 8'(cur_col);
      u.view_top_out = 6'(top_row);
      u.cursor_on = shown[0];
      expected_updates.push_back(u);
   endfunction

   // Send one word; called just after a falling edge, returns just after one.
   task automatic send_word(input logic [2:0] fn, input logic [7:0] ch, input logic [7:0] sl,
                            input logic [5:0] row, input logic [6:0] col);
      while (idle_on && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {col, row, sl, ch, fn};
      do @(posedge clock); while (!req_tready);
      predict_update({col, row, sl, ch, fn});
      words_sent++;
      @(negedge clock);
   endtask

   // Random word of a console session: mostly text and newlines, with the rest mixed in.
   task automatic send_random_word();
      int unsigned pick;
      logic [2:0]  fn;
      logic [7:0]  ch;
      pick = $urandom_range(99);
      fn = FN_PUT;
      ch = 8'($urandom_range(255));
      if (pick < 45) fn = FN_PUT;
      else if (pick < 62) ch = CH_NEWLINE;
      else if (pick < 70) ch = CH_BACKSPACE;
      else if (pick < 79) fn = FN_SCROLL;
      else if (pick < 88) fn = FN_TICK;
      else if (pick < 90) fn = FN_REFIT;
      else if (pick < 97) fn = FN_READ;
      else if (pick < 99) fn = 3'($urandom_range(7, 6));
      else fn = FN_CLEAR;
      send_word(fn, ch, 8'($urandom_range(255)), 6'($urandom_range(63)),
                7'($urandom_range(127)));
   endtask

   // Drop the input valid and wait until every expected update has come, then let the bench idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_updates.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Register write followed by a read-back.
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      logic [31:0] mask;
      mask = (idx == REG_COLS) ? 32'hFF : (idx == REG_ROWS) ? 32'h7F : 32'hFFFF;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if ((csr_prdata & mask) != (val & mask)) begin
         $display("%0t: register %0d read exp %h got %h", $time, idx, val & mask, csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_COLS:   grid_cols = val & mask;
         REG_ROWS:   grid_rows = val & mask;
         REG_PERIOD: period = val & mask;
         default: ;
      endcase
   endtask

   task automatic set_grid(input int unsigned cols, input int unsigned rows,
                           input int unsigned per);
      drain();
      csr_write(REG_COLS, cols);
      csr_write(REG_ROWS, rows);
      csr_write(REG_PERIOD, per);
   endtask

   // Extremes of every field, every function code and the named special cases.
   task automatic test_directed();
      send_word(FN_PUT, CH_BACKSPACE, 8'd0, 6'd0, 7'd0);   // backspace at column zero
      send_word(FN_PUT, 8'd65, 8'd0, 6'd0, 7'd0);
      send_word(FN_PUT, 8'd255, 8'hFF, 6'd63, 7'd127);
      send_word(FN_PUT, 8'd0, 8'd0, 6'd0, 7'd0);
      send_word(FN_PUT, CH_BACKSPACE, 8'd0, 6'd0, 7'd0);
      send_word(FN_READ, 8'd0, 8'd0, 6'd0, 7'd0);
      send_word(FN_READ, 8'hFF, 8'hFF, 6'd63, 7'd127);
      send_word(FN_PUT, CH_NEWLINE, 8'd0, 6'd0, 7'd0);
      send_word(FN_SCROLL, 8'd0, 8'd64, 6'd0, 7'd0);
      send_word(FN_SCROLL, 8'd0, 8'hC0, 6'd0, 7'd0);      // minus 64
      send_word(FN_SCROLL, 8'd0, 8'h80, 6'd0, 7'd0);
      send_word(FN_SCROLL, 8'd0, 8'h7F, 6'd0, 7'd0);
      send_word(FN_TICK, 8'd0, 8'd0, 6'd0, 7'd0);
      send_word(FN_REFIT, 8'd0, 8'd0, 6'd0, 7'd0);
      send_word(3'd6, 8'hAA, 8'h55, 6'd21, 7'd42);
      send_word(3'd7, 8'h55, 8'hAA, 6'd42, 7'd85);
      send_word(FN_CLEAR, 8'd0, 8'd0, 6'd0, 7'd0);
      send_word(FN_READ, 8'd0, 8'd0, 6'd0, 7'd0);
      // Narrow grid: wrap on the second character, ticks toggle every time.
      set_grid(1, 1, 1);
      send_word(FN_PUT, 8'd66, 8'd0, 6'd0, 7'd0);
      send_word(FN_PUT, 8'd67, 8'd0, 6'd0, 7'd0);
      send_word(FN_TICK, 8'd0, 8'd0, 6'd0, 7'd0);
      send_word(FN_TICK, 8'd0, 8'd0, 6'd0, 7'd0);
      // Grid widened past the store and period lowered below the count.
      set_grid(255, 127, 0);
      send_word(FN_REFIT, 8'd0, 8'd0, 6'd0, 7'd0);
      send_word(FN_TICK, 8'd0, 8'd0, 6'd0, 7'd0);
   endtask

   // Random session under one grid setting.
   task automatic test_session(input int unsigned cols, input int unsigned rows,
                               input int unsigned per, input int unsigned count,
                               input bit quiet_start);
      set_grid(cols, rows, per);
      for (int i = 0; i < count; i++) begin
         idle_on = !(quiet_start && i < 150);
         send_random_word();
      end
      idle_on = 1'b1;
   endtask

   // Sender holds off mid-stream until all updates are back, then carries on.
   task automatic test_holdoff();
      for (int i = 0; i < 40; i++) send_random_word();
      drain();
      for (int i = 0; i < 40; i++) send_random_word();
   endtask

   initial begin
      wipe_store();
      cur_row = 0;
      cur_col = 0;
      top_row = 0;
      blink_cnt = 0;
      shown = 1;
      grid_cols = RST_COLS;
      grid_rows = RST_ROWS;
      period = RST_PERIOD;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_session(120, 64, 3000, 200, 1'b0);
      test_session(1, 1, 1, 200, 1'b0);
      test_session(128, 64, 2, 300, 1'b1);
      test_session(40, 10, 5, 350, 1'b0);
      test_session(0, 0, 3, 150, 1'b0);
      test_session(8, 63, 65535, 200, 1'b0);
      test_holdoff();
      test_session(200, 100, 7, 300, 1'b0);
      drain();
      $display("Sent %0d words over eight grid settings, %0d updates checked.", words_sent,
               updates_seen);
      $display("Covered wraps, backspace, store scrolling, view clamping, blink and clears.");
      if (errors == 0 && expected_updates.size() == 0) begin
         $display("tb_text_console_buffer_top: done, clean");
      end else begin
         $display("%0d mismatches, %0d updates never came", errors, expected_updates.size());
         $display("tb_text_console_buffer_top: done, errors");
      end
      $finish;
   end

endmodule
